/* sv/srpd_pkg.sv */
package srpd_pkg;

  // Field widths
  localparam int SAMPLE_W  = 13;
  localparam int SQ_W      = 24;
  localparam int PERIOD_W  = 16;
  localparam int MV_W      = 12;
  localparam int DUTY_W    = 16;

  // Amplitude arithmetic: q = 512*sum/WINDOW, amp = isqrt(q) in mV with 4 fraction bits
  localparam int AMP_SCALE_SH = 9;
  localparam int FRAC_SH      = 4;
  localparam int Q_W          = SQ_W + AMP_SCALE_SH;
  localparam int ROOT_W       = (Q_W + 1) / 2;
  localparam int MUL_STEPS    = PERIOD_W;
  localparam int PROD_W       = ROOT_W + PERIOD_W;

  // Stream payload widths
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 32;

  // Configuration registers
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_OFFSET_MV = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_SPAN_MV   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_OFFSET_MV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_SPAN_MV   = 3'd4;

  localparam logic [PERIOD_W-1:0] RST_PWM_PERIOD     = 16'd20000;
  localparam logic [MV_W-1:0]     RST_SLOW_OFFSET_MV = 12'd5;
  localparam logic [MV_W-1:0]     RST_SLOW_SPAN_MV   = 12'd45;
  localparam logic [MV_W-1:0]     RST_FAST_OFFSET_MV = 12'd10;
  localparam logic [MV_W-1:0]     RST_FAST_SPAN_MV   = 12'd140;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [MV_W-1:0]     offset;
    logic [MV_W-1:0]     span;
  } srpd_chan_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } srpd_lane_stat_t;

endpackage

/* sv/srpd_ram.sv */
module srpd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/srpd_div.sv */
// Restoring divider, one quotient bit per cycle.
// rem_init must be below divisor; quotient ends in the low 'steps' bits of quo.
module srpd_div #(
  parameter int RW = 17,
  parameter int QW = 33,
  parameter int SW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [RW-1:0] rem_init,
  input  logic [QW-1:0] low,
  input  logic [RW-1:0] divisor,
  input  logic [SW-1:0] steps,
  output logic          done,
  output logic [QW-1:0] quo
);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] low_r, low_nxt;
  logic [RW-1:0] dvs_r, dvs_nxt;
  logic [RW:0]   r2;
  logic [RW:0]   diff;
  logic          ge;
  logic          last;

  assign r2   = {rem_r, low_r[QW-1]};
  assign ge   = r2 >= {1'b0, dvs_r};
  assign diff = r2 - {1'b0, dvs_r};
  assign last = cnt_r == SW'(1);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps;
      rem_nxt  = rem_init;
      low_nxt  = low;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[RW-1:0] : r2[RW-1:0];
      low_nxt = {low_r[QW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quo  = low_r;

endmodule

/* sv/srpd_sqrt.sv */
// Digit-by-digit integer square root, two radicand bits per cycle.
module srpd_sqrt #(
  parameter int IW = 34
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [IW-1:0]    radicand,
  output logic             done,
  output logic [IW/2-1:0]  root
);

  localparam int RTW = IW / 2;
  localparam int CW  = $clog2(RTW + 1);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [IW-1:0]  x_r, x_nxt;
  logic [RTW+1:0] rem_r, rem_nxt;
  logic [RTW-1:0] root_r, root_nxt;
  logic [RTW+3:0] r2;
  logic [RTW+3:0] trial;
  logic [RTW+3:0] diff;
  logic           ge;

  assign r2    = {rem_r, x_r[IW-1:IW-2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign ge    = r2 >= trial;
  assign diff  = r2 - trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(RTW);
      x_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[RTW+1:0] : r2[RTW+1:0];
      root_nxt = {root_r[RTW-2:0], ge};
      x_nxt    = {x_r[IW-3:0], 2'b00};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* sv/srpd_lane.sv */
// One channel: square ring, running sum, and the serial duty pipeline.
module srpd_lane #(
  parameter int WINDOW = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [srpd_pkg::SAMPLE_W-1:0] sample,
  input  logic [$clog2(WINDOW)-1:0]           ptr,
  input  logic                                full,
  input  srpd_pkg::srpd_chan_cfg_t            ccfg,
  output srpd_pkg::srpd_lane_stat_t           stat,
  output logic [srpd_pkg::DUTY_W-1:0]         duty
);

  import srpd_pkg::*;

  localparam int PW      = $clog2(WINDOW);
  localparam int SUM_W   = SQ_W + PW;
  localparam int WIN_W   = $clog2(WINDOW + 1);
  localparam int DIV_RW  = (WIN_W > DUTY_W) ? WIN_W : DUTY_W;
  localparam int DIV_SW  = $clog2(Q_W + 1);
  localparam int MCNT_W  = $clog2(MUL_STEPS);
  localparam int SQRT_IW = 2 * ROOT_W;

  typedef enum logic [8:0] {
    L_IDLE = 9'b000000001,
    L_SUB  = 9'b000000010,
    L_SQ   = 9'b000000100,
    L_ADD  = 9'b000001000,
    L_QDIV = 9'b000010000,
    L_SQRT = 9'b000100000,
    L_MUL  = 9'b001000000,
    L_DDIV = 9'b010000000,
    L_DONE = 9'b100000000
  } lane_state_t;

  lane_state_t          state_r, state_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [PW-1:0]        ptr_r, ptr_nxt;
  logic                 full_r, full_nxt;
  logic [PROD_W-1:0]    mcand_r, mcand_nxt;
  logic [MUL_STEPS-1:0] mplier_r, mplier_nxt;
  logic [PROD_W-1:0]    acc_r, acc_nxt;
  logic [MCNT_W-1:0]    mcnt_r, mcnt_nxt;
  logic [DUTY_W-1:0]    duty_r, duty_nxt;

  logic [SAMPLE_W-1:0]  sample_u;
  logic [SAMPLE_W-1:0]  sample_abs;
  logic [PROD_W-1:0]    acc_step;
  logic                 mul_last;
  logic [SQ_W-1:0]      sq;
  logic [SUM_W-1:0]     sum_add;
  logic [SUM_W-1:0]     sum_sub;
  logic [SQ_W-1:0]      ram_rdata;
  logic                 ram_we;

  logic                 div_start;
  logic [DIV_RW-1:0]    div_rem;
  logic [Q_W-1:0]       div_low;
  logic [DIV_RW-1:0]    div_dvs;
  logic [DIV_SW-1:0]    div_steps;
  logic                 div_done;
  logic [Q_W-1:0]       div_quo;

  logic                 sq_start;
  logic                 sq_done;
  logic [ROOT_W-1:0]    sq_root;

  logic [DUTY_W-1:0]    off16;
  logic [DUTY_W-1:0]    span16;
  logic                 amp_le;
  logic [ROOT_W-1:0]    d;
  logic                 d_ge;

  assign sample_u   = sample;
  assign sample_abs = sample_u[SAMPLE_W-1] ? (~sample_u + 1'b1) : sample_u;

  // one multiplier bit per cycle
  assign acc_step = acc_r + (mplier_r[0] ? mcand_r : '0);
  assign mul_last = mcnt_r == MCNT_W'(MUL_STEPS - 1);

  // only a sample of -4096 overflows 24 bits
  assign sq      = (acc_r[PROD_W-1:SQ_W] != '0) ? '1 : acc_r[SQ_W-1:0];
  assign sum_add = sum_r + SUM_W'(sq);
  assign sum_sub = sum_r - SUM_W'(ram_rdata);

  assign off16  = {ccfg.offset, {FRAC_SH{1'b0}}};
  assign span16 = {ccfg.span, {FRAC_SH{1'b0}}};
  assign amp_le = sq_root <= ROOT_W'(off16);
  assign d      = sq_root - ROOT_W'(off16);
  // zero span falls in here too: d >= 0 always
  assign d_ge   = d >= ROOT_W'(span16);

  always_comb begin
    state_nxt  = state_r;
    sum_nxt    = sum_r;
    ptr_nxt    = ptr_r;
    full_nxt   = full_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    mcnt_nxt   = mcnt_r;
    duty_nxt   = duty_r;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    div_rem    = '0;
    div_low    = '0;
    div_dvs    = '0;
    div_steps  = '0;
    sq_start   = 1'b0;
    case (state_r)
      L_IDLE: begin
        if (start) begin
          ptr_nxt    = ptr;
          full_nxt   = full;
          mcand_nxt  = PROD_W'(sample_abs);
          mplier_nxt = MUL_STEPS'(sample_abs);
          acc_nxt    = '0;
          mcnt_nxt   = '0;
          state_nxt  = L_SUB;
        end
      end
      L_SUB: begin
        // ring data for ptr arrived this cycle
        if (full_r) begin
          sum_nxt = sum_sub;
        end
        state_nxt = L_SQ;
      end
      L_SQ, L_MUL: begin
        acc_nxt    = acc_step;
        mcand_nxt  = {mcand_r[PROD_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[MUL_STEPS-1:1]};
        mcnt_nxt   = mcnt_r + 1'b1;
        if (mul_last) begin
          if (state_r == L_SQ) begin
            state_nxt = L_ADD;
          end else begin
            // product >> 16 is below 16*span, so 16 quotient bits suffice
            div_start = 1'b1;
            div_rem   = DIV_RW'(acc_step[2*DUTY_W-1:DUTY_W]);
            div_low   = {acc_step[DUTY_W-1:0], {(Q_W-DUTY_W){1'b0}}};
            div_dvs   = DIV_RW'(span16);
            div_steps = DIV_SW'(DUTY_W);
            state_nxt = L_DDIV;
          end
        end
      end
      L_ADD: begin
        ram_we    = 1'b1;
        sum_nxt   = sum_add;
        // 512*sum / WINDOW; sum >> 24 is always below WINDOW
        div_start = 1'b1;
        div_rem   = DIV_RW'(sum_add[SUM_W-1:SQ_W]);
        div_low   = {sum_add[SQ_W-1:0], {AMP_SCALE_SH{1'b0}}};
        div_dvs   = DIV_RW'(WINDOW);
        div_steps = DIV_SW'(Q_W);
        state_nxt = L_QDIV;
      end
      L_QDIV: begin
        if (div_done) begin
          sq_start  = 1'b1;
          state_nxt = L_SQRT;
        end
      end
      L_SQRT: begin
        if (sq_done) begin
          if (amp_le || ccfg.period == '0) begin
            duty_nxt  = '0;
            state_nxt = L_DONE;
          end else if (d_ge) begin
            duty_nxt  = ccfg.period;
            state_nxt = L_DONE;
          end else begin
            mcand_nxt  = PROD_W'(d);
            mplier_nxt = ccfg.period;
            acc_nxt    = '0;
            mcnt_nxt   = '0;
            state_nxt  = L_MUL;
          end
        end
      end
      L_DDIV: begin
        if (div_done) begin
          duty_nxt  = div_quo[DUTY_W-1:0];
          state_nxt = L_DONE;
        end
      end
      L_DONE: begin
        state_nxt = L_IDLE;
      end
      default: begin
        state_nxt = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
    end
    ptr_r    <= ptr_nxt;
    full_r   <= full_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    mcnt_r   <= mcnt_nxt;
    duty_r   <= duty_nxt;
  end

  srpd_ram #(
    .WIDTH (SQ_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (sq),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  srpd_div #(
    .RW (DIV_RW),
    .QW (Q_W),
    .SW (DIV_SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem),
    .low      (div_low),
    .divisor  (div_dvs),
    .steps    (div_steps),
    .done     (div_done),
    .quo      (div_quo)
  );

  srpd_sqrt #(
    .IW (SQRT_IW)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand ({{(SQRT_IW-Q_W){1'b0}}, div_quo}),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign stat.busy = state_r != L_IDLE;
  assign stat.done = state_r == L_DONE;
  assign duty      = duty_r;

endmodule

/* sv/sliding_rms_to_pwm_duty.sv */
// Channel  Dir  Beat payload                                  Accepted when
// in_      in   tdata: slow/fast sample mV, tuser: charging   in_tvalid & in_tready
// out_     out  tdata: slow/fast duty counts                  out_tvalid & out_tready
// cfg_     in   cfg_index, cfg_data register write            cfg_valid & cfg_ready
//
// An input beat passes the bit-serial square multiplier, window divider, root, duty
// multiplier and duty divider on its way to the output register; a duty that comes
// out zero or full scale skips the duty multiplier and divider. Both channels run
// side by side. A charging beat goes straight to the pending result state.
// rst_n is synchronous; the square rings are not cleared, an entry is read only
// after it was written. in_tready drops while an item is in work or its result is
// blocked behind a stalled output beat; cfg_ready is always high.
module sliding_rms_to_pwm_duty #(
  parameter int WINDOW = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // slave side
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [12:0] slow_sample_mv, [25:13] fast_sample_mv, [31:26] zero
  input  logic [srpd_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [0] charging
  input  logic [srpd_pkg::IN_TUSER_W-1:0]      in_tuser,
  // master side
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [15:0] slow_duty, [31:16] fast_duty
  output logic [srpd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // config writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [srpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [srpd_pkg::PERIOD_W-1:0]        cfg_data
);

  import srpd_pkg::*;

  localparam int PW = $clog2(WINDOW);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,   // waiting for a beat
    T_RUN  = 3'b010,   // lanes working
    T_PEND = 3'b100    // result ready, waiting for the output register
  } top_state_t;

  top_state_t          state_r, state_nxt;
  logic [PW-1:0]       ptr_r, ptr_nxt;
  logic                full_r, full_nxt;
  logic                sdone_r, sdone_nxt;
  logic                fdone_r, fdone_nxt;
  logic [DUTY_W-1:0]   res_slow_r, res_slow_nxt;
  logic [DUTY_W-1:0]   res_fast_r, res_fast_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [MV_W-1:0]     slow_off_r, slow_off_nxt;
  logic [MV_W-1:0]     slow_span_r, slow_span_nxt;
  logic [MV_W-1:0]     fast_off_r, fast_off_nxt;
  logic [MV_W-1:0]     fast_span_r, fast_span_nxt;

  logic                in_fire;
  logic                charging;
  logic                lane_start;
  logic                out_free;

  srpd_chan_cfg_t      slow_cfg, fast_cfg;
  srpd_lane_stat_t     slow_stat, fast_stat;
  logic [DUTY_W-1:0]   slow_duty, fast_duty;

  assign in_tready  = state_r == T_IDLE;
  assign in_fire    = in_tvalid && in_tready;
  assign charging   = in_tuser[0];
  // charging beats leave the window untouched
  assign lane_start = in_fire && !charging;
  assign out_free   = !out_valid_r || out_tready;

  assign slow_cfg = '{period: period_r, offset: slow_off_r, span: slow_span_r};
  assign fast_cfg = '{period: period_r, offset: fast_off_r, span: fast_span_r};

  // Config registers, values masked to their widths
  always_comb begin
    period_nxt    = period_r;
    slow_off_nxt  = slow_off_r;
    slow_span_nxt = slow_span_r;
    fast_off_nxt  = fast_off_r;
    fast_span_nxt = fast_span_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_PWM_PERIOD:     period_nxt    = cfg_data;
        REG_SLOW_OFFSET_MV: slow_off_nxt  = cfg_data[MV_W-1:0];
        REG_SLOW_SPAN_MV:   slow_span_nxt = cfg_data[MV_W-1:0];
        REG_FAST_OFFSET_MV: fast_off_nxt  = cfg_data[MV_W-1:0];
        REG_FAST_SPAN_MV:   fast_span_nxt = cfg_data[MV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    full_nxt      = full_r;
    sdone_nxt     = sdone_r;
    fdone_nxt     = fdone_r;
    res_slow_nxt  = res_slow_r;
    res_fast_nxt  = res_fast_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    case (state_r)
      T_IDLE: begin
        if (in_fire) begin
          if (charging) begin
            res_slow_nxt = '0;
            res_fast_nxt = '0;
            state_nxt    = T_PEND;
          end else begin
            sdone_nxt = 1'b0;
            fdone_nxt = 1'b0;
            // ring slot advances here; the lanes latch the old value
            if (ptr_r == PW'(WINDOW - 1)) begin
              ptr_nxt  = '0;
              full_nxt = 1'b1;
            end else begin
              ptr_nxt = ptr_r + 1'b1;
            end
            state_nxt = T_RUN;
          end
        end
      end
      T_RUN: begin
        // early-out paths let the two lanes finish at different times
        if (slow_stat.done) begin
          sdone_nxt    = 1'b1;
          res_slow_nxt = slow_duty;
        end
        if (fast_stat.done) begin
          fdone_nxt    = 1'b1;
          res_fast_nxt = fast_duty;
        end
        if (sdone_nxt && fdone_nxt) begin
          state_nxt = T_PEND;
        end
      end
      T_PEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_fast_r, res_slow_r};
          state_nxt     = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      ptr_r       <= '0;
      full_r      <= 1'b0;
      sdone_r     <= 1'b0;
      fdone_r     <= 1'b0;
      out_valid_r <= 1'b0;
      period_r    <= RST_PWM_PERIOD;
      slow_off_r  <= RST_SLOW_OFFSET_MV;
      slow_span_r <= RST_SLOW_SPAN_MV;
      fast_off_r  <= RST_FAST_OFFSET_MV;
      fast_span_r <= RST_FAST_SPAN_MV;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      full_r      <= full_nxt;
      sdone_r     <= sdone_nxt;
      fdone_r     <= fdone_nxt;
      out_valid_r <= out_valid_nxt;
      period_r    <= period_nxt;
      slow_off_r  <= slow_off_nxt;
      slow_span_r <= slow_span_nxt;
      fast_off_r  <= fast_off_nxt;
      fast_span_r <= fast_span_nxt;
    end
    res_slow_r <= res_slow_nxt;
    res_fast_r <= res_fast_nxt;
    out_data_r <= out_data_nxt;
  end

  srpd_lane #(
    .WINDOW (WINDOW)
  ) u_slow (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lane_start),
    .sample (in_tdata[SAMPLE_W-1:0]),
    .ptr    (ptr_r),
    .full   (full_r),
    .ccfg   (slow_cfg),
    .stat   (slow_stat),
    .duty   (slow_duty)
  );

  srpd_lane #(
    .WINDOW (WINDOW)
  ) u_fast (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lane_start),
    .sample (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .ptr    (ptr_r),
    .full   (full_r),
    .ccfg   (fast_cfg),
    .stat   (fast_stat),
    .duty   (fast_duty)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

`ifndef SYNTHESIS
  a_ready_lanes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!slow_stat.busy && !fast_stat.busy))
    else $error("input ready while a lane is busy");

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (slow_stat.done || fast_stat.done) |-> (state_r == T_RUN))
    else $error("lane finished outside of a run");

  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("window full flag cleared");

  a_charge_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && charging) |=> (ptr_r == $past(ptr_r) && full_r == $past(full_r)))
    else $error("charging beat moved the ring pointer");
`endif

endmodule

/* tb/sv/tb_sliding_rms_to_pwm_duty.sv */
module tb_sliding_rms_to_pwm_duty;
  import srpd_pkg::*;

  // Window depth handed to the block; the duty predictor keeps rings of the same size.
  localparam int WIN = 1024;
  // Run limit; the whole run stays well under this.
  localparam int LIMIT_CYCLES = 1000000;
  // Cycles to watch the output after the last duty pair came back (above one beat latency).
  localparam int TAIL_CYCLES = 150;
  // Long output hold-off, longer than one beat through the block.
  localparam int HOLD_CYCLES = 500;
  // Mismatches printed in full; later ones are only counted.
  localparam int MAX_REPORTS = 10;
  // Index outside the register map; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [DUTY_W-1:0] fast_duty;
    logic [DUTY_W-1:0] slow_duty;
  } duty_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PERIOD_W-1:0] cfg_data = '0;

  // Idling knobs, in percent of cycles.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Hold-off request: the test flips hold_toggle, the ready process counts the cycles.
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int hold_cnt = 0;

  int fail_count = 0;
  int cycle_count = 0;

  // Duty pairs predicted for accepted beats, oldest first.
  duty_pair_t pending_duties[$];

  // Predictor state: channel settings, square history rings, running sums, write slot.
  srpd_chan_cfg_t slow_set = {RST_PWM_PERIOD, RST_SLOW_OFFSET_MV, RST_SLOW_SPAN_MV};
  srpd_chan_cfg_t fast_set = {RST_PWM_PERIOD, RST_FAST_OFFSET_MV, RST_FAST_SPAN_MV};
  bit [SQ_W-1:0] slow_ring[WIN];
  bit [SQ_W-1:0] fast_ring[WIN];
  longint unsigned slow_sum = 0;
  longint unsigned fast_sum = 0;
  int win_ptr = 0;
  bit win_full = 1'b0;

  sliding_rms_to_pwm_duty #(
    .WINDOW(WIN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // Integer square root, digit by digit.
  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned probe;
    res = 0;
    probe = 64'h1 << 62;
    while (probe > x) probe = probe >> 2;
    while (probe != 0) begin
      if (x >= res + probe) begin
        x = x - res - probe;
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // Square of a 13-bit sample; only -4096 overflows 24 bits and saturates.
  function automatic logic [SQ_W-1:0] square_sat(logic signed [SAMPLE_W-1:0] mv);
    int mag;
    longint unsigned sq;
    mag = int'(mv);
    if (mag < 0) mag = -mag;
    sq = mag * mag;
    if (sq > 64'hFF_FFFF) sq = 64'hFF_FFFF;
    return sq[SQ_W-1:0];
  endfunction

  // Amplitude (mV, 4 fraction bits) from the window power, then offset/span scaling.
  function automatic logic [DUTY_W-1:0] duty_from_power(longint unsigned sq_sum,
                                                       srpd_chan_cfg_t c);
    longint unsigned amp;
    longint unsigned off;
    longint unsigned per;
    longint unsigned spn;
    longint unsigned duty;
    amp = floor_sqrt((sq_sum << AMP_SCALE_SH) / WIN);
    off = c.offset;
    off = off << FRAC_SH;
    per = c.period;
    spn = c.span;
    if (amp <= off || per == 0) return '0;
    // zero span: any amplitude above the offset is full scale
    if (spn == 0) return c.period;
    duty = (per * (amp - off)) / (spn << FRAC_SH);
    if (duty > per) return c.period;
    return duty[DUTY_W-1:0];
  endfunction

  // One accepted beat: update the window (unless charging) and return both duties.
  function automatic duty_pair_t rms_duty_step(logic signed [SAMPLE_W-1:0] slow_mv,
                                              logic signed [SAMPLE_W-1:0] fast_mv,
                                              logic charging);
    duty_pair_t r;
    logic [SQ_W-1:0] slow_sq;
    logic [SQ_W-1:0] fast_sq;
    r = '0;
    // charging: duties forced low, window frozen
    if (charging) return r;
    slow_sq = square_sat(slow_mv);
    fast_sq = square_sat(fast_mv);
    if (win_full) begin
      slow_sum = slow_sum - slow_ring[win_ptr];
      fast_sum = fast_sum - fast_ring[win_ptr];
    end
    slow_sum = slow_sum + slow_sq;
    fast_sum = fast_sum + fast_sq;
    slow_ring[win_ptr] = slow_sq;
    fast_ring[win_ptr] = fast_sq;
    if (win_ptr == WIN - 1) begin
      win_ptr = 0;
      win_full = 1'b1;
    end else begin
      win_ptr = win_ptr + 1;
    end
    r.slow_duty = duty_from_power(slow_sum, slow_set);
    r.fast_duty = duty_from_power(fast_sum, fast_set);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: ready generation and result checking
  // ---------------------------------------------------------------------------

  // Random stalls, plus a long hold-off counted here when the test asks for one.
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_cnt <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic note_failure(string msg);
    if (fail_count < MAX_REPORTS) $display("ERROR @%0d: %s", cycle_count, msg);
    fail_count = fail_count + 1;
  endtask

  // Every output beat is compared field by field with the oldest prediction.
  always @(posedge clk) begin
    duty_pair_t want;
    duty_pair_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.slow_duty = out_tdata[DUTY_W-1:0];
      got.fast_duty = out_tdata[2*DUTY_W-1:DUTY_W];
      if (pending_duties.size() == 0) begin
        note_failure($sformatf("unexpected beat slow=%0d fast=%0d",
                               got.slow_duty, got.fast_duty));
      end else begin
        want = pending_duties.pop_front();
        if (got.slow_duty !== want.slow_duty || got.fast_duty !== want.fast_duty)
          note_failure($sformatf("duty mismatch: expected slow=%0d fast=%0d, got slow=%0d fast=%0d",
                                 want.slow_duty, want.fast_duty,
                                 got.slow_duty, got.fast_duty));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one sample beat; valid stays up after acceptance unless a gap follows.
  task automatic offer_sample(logic signed [SAMPLE_W-1:0] slow_mv,
                              logic signed [SAMPLE_W-1:0] fast_mv,
                              logic charging);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W - 2*SAMPLE_W){1'b0}}, fast_mv, slow_mv};
    in_tuser <= charging;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_duties.push_back(rms_duty_step(slow_mv, fast_mv, charging));
  endtask

  // Stop sending and wait for every predicted duty pair to come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Register write; cfg_valid is left high so back-to-back writes need no gap.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // narrow registers keep only their low bits
    case (idx)
      REG_PWM_PERIOD: begin
        slow_set.period = value;
        fast_set.period = value;
      end
      REG_SLOW_OFFSET_MV: slow_set.offset = value[MV_W-1:0];
      REG_SLOW_SPAN_MV:   slow_set.span = value[MV_W-1:0];
      REG_FAST_OFFSET_MV: fast_set.offset = value[MV_W-1:0];
      REG_FAST_SPAN_MV:   fast_set.span = value[MV_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [PERIOD_W-1:0] period,
                                logic [PERIOD_W-1:0] slow_off, logic [PERIOD_W-1:0] slow_spn,
                                logic [PERIOD_W-1:0] fast_off, logic [PERIOD_W-1:0] fast_spn);
    write_reg(REG_PWM_PERIOD, period);
    write_reg(REG_SLOW_OFFSET_MV, slow_off);
    write_reg(REG_SLOW_SPAN_MV, slow_spn);
    write_reg(REG_FAST_OFFSET_MV, fast_off);
    write_reg(REG_FAST_SPAN_MV, fast_spn);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_level();
    case ($urandom_range(7))
      0: return 0;
      1: return 3;
      2: return 20;
      3: return 60;
      4: return 200;
      5: return 800;
      6: return 2500;
      default: return 4095;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sample_within(int lvl);
    int v;
    v = int'($urandom_range(2 * lvl)) - lvl;
    return v[SAMPLE_W-1:0];
  endfunction

  // Full-scale values, -4096 included (the one square that saturates).
  function automatic logic signed [SAMPLE_W-1:0] extreme_sample();
    case ($urandom_range(2))
      0: return 13'sd4095;
      1: return -13'sd4095;
      default: return -13'sd4096;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: zero input, full scale both signs, saturating square, charging
  // with loud samples (window must not move), alternating bit patterns.
  task automatic test_directed_extremes();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    offer_sample(13'sd0, 13'sd0, 1'b0);
    offer_sample(13'sd4095, -13'sd4095, 1'b0);
    offer_sample(-13'sd4096, 13'sd4095, 1'b0);
    offer_sample(13'sd4095, 13'sd4095, 1'b1);
    offer_sample(-13'sd1, 13'sd1, 1'b0);
    offer_sample(13'sd1000, -13'sd2000, 1'b1);
    offer_sample(13'h0AAA, 13'h1555, 1'b0);
    offer_sample(13'sd20, -13'sd50, 1'b0);
    wait_drained();
  endtask

  // Every register, masking of wide data, an unmapped index, zero period, zero span,
  // and the range ends of offset and span.
  task automatic test_register_writes();
    write_reg(REG_SPARE, 16'hFFFF);
    cfg_valid <= 1'b0;
    offer_sample(13'sd300, -13'sd300, 1'b0);
    wait_drained();

    // zero period: both duties stay low
    write_reg(REG_PWM_PERIOD, 16'd0);
    cfg_valid <= 1'b0;
    offer_sample(13'sd4095, 13'sd4095, 1'b0);
    offer_sample(-13'sd7, 13'sd9, 1'b1);
    wait_drained();

    // widest period, tightest slow span, fast offset at the top via masking
    apply_settings(16'hFFFF, 16'd0, 16'd1, 16'hFFFF, 16'd4095);
    offer_sample(13'sd25, -13'sd25, 1'b0);
    offer_sample(-13'sd4096, 13'sd0, 1'b0);
    wait_drained();

    // zero span both channels: above offset gives full period, at or below gives zero
    apply_settings(16'd20000, 16'hF005, 16'hF000, 16'd4095, 16'd0);
    offer_sample(13'sd40, 13'sd40, 1'b0);
    offer_sample(13'sd0, 13'sd0, 1'b0);
    wait_drained();
  endtask

  // Bursts of random samples at a random level, so the window RMS wanders across
  // the offset/span range; a few charging and full-scale beats mixed in.
  task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
    int slow_lvl;
    int fast_lvl;
    int left;
    int roll;
    left = 0;
    slow_lvl = 0;
    fast_lvl = 0;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if (left == 0) begin
        slow_lvl = pick_level();
        fast_lvl = pick_level();
        left = $urandom_range(120, 10);
      end
      left = left - 1;
      roll = $urandom_range(99);
      if (roll < 6)
        offer_sample(sample_within(4095), sample_within(4095), 1'b1);
      else if (roll < 8)
        offer_sample(extreme_sample(), extreme_sample(), 1'b0);
      else
        offer_sample(sample_within(slow_lvl), sample_within(fast_lvl), 1'b0);
    end
    wait_drained();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering beats,
  // so a finished result backs up and the input stalls.
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_toggle = ~hold_toggle;
    for (int i = 0; i < 24; i++)
      offer_sample(sample_within(60), sample_within(4095), ($urandom_range(9) == 0));
    wait_drained();
  endtask

  // Sender pauses mid-stream until every result is back, then resumes.
  task automatic test_drain_pause();
    send_idle_pct = 10;
    recv_stall_pct = 30;
    for (int i = 0; i < 15; i++)
      offer_sample(sample_within(30), sample_within(150), 1'b0);
    wait_drained();
    for (int i = 0; i < 15; i++)
      offer_sample(sample_within(30), sample_within(150), ($urandom_range(9) == 0));
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_register_writes();

    // four idling profiles, each under its own settings
    apply_settings(16'd20000, 16'd5, 16'd45, 16'd10, 16'd140);
    test_random_traffic(400, 0, 0);
    apply_settings(16'd65535, 16'd0, 16'd4095, 16'd100, 16'd2000);
    test_random_traffic(400, 59, 0);
    apply_settings(16'd1000, 16'd20, 16'd300, 16'd50, 16'd600);
    test_random_traffic(400, 0, 59);
    apply_settings(16'd12345, 16'd0, 16'd4095, 16'd2000, 16'd1);
    test_random_traffic(400, 19, 19);

    apply_settings(16'd1, 16'd30, 16'd1, 16'd0, 16'd4095);
    test_output_hold();
    apply_settings(16'd20000, 16'd5, 16'd45, 16'd10, 16'd140);
    test_drain_pause();

    // watch for stray beats after the last expected one
    in_tvalid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_duties.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
